// ===== sv/clp_pkg.sv =====
package clp_pkg;

    localparam int unsigned LenW    = 6;
    localparam int unsigned PieceW  = 5;
    localparam int unsigned CornerW = 3;
    localparam int unsigned SlotW   = 4;
    localparam int unsigned CoordW  = 16;

    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChLowerB = 8'h62;
    localparam logic [7:0] ChUpperB = 8'h42;

    localparam logic FuncByte  = 1'b0;
    localparam logic FuncClear = 1'b1;

    localparam logic KindPiece  = 1'b0;
    localparam logic KindCorner = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              piece;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              color;
    } t_line_end;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == ChSpace) || (c >= ChTab && c <= ChCr);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= ChZero) && (c <= ChNine);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        is_sign = (c == ChPlus) || (c == ChMinus);
    endfunction

    function automatic logic [CoordW-1:0] mac10(input logic [CoordW-1:0] acc,
                                                input logic [7:0]        c);
        mac10 = (acc << 3) + (acc << 1) + {{(CoordW-4){1'b0}}, c[3:0]};
    endfunction

endpackage

// ===== sv/clp_field_scan.sv =====
module clp_field_scan #(
    parameter int unsigned LINE_CHARS = 47
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_func,
    input  logic [7:0]         i_rx_byte,
    output clp_pkg::t_line_end o_end
);

    typedef enum logic [3:0] {
        S_X_PRE,
        S_X_SIGN,
        S_X_DIG,
        S_Y_PRE,
        S_Y_SIGN,
        S_Y_DIG,
        S_AFTER_Y,
        S_WORD,
        S_FAIL
    } t_scan_state;

    localparam logic [clp_pkg::LenW-1:0] LineMax = clp_pkg::LenW'(LINE_CHARS);

    t_scan_state                   r_state, n_state;
    logic                          r_text_end, n_text_end;
    logic [clp_pkg::LenW-1:0]      r_len, n_len;
    logic [clp_pkg::CoordW-1:0]    r_x_acc, n_x_acc;
    logic [clp_pkg::CoordW-1:0]    r_y_acc, n_y_acc;
    logic                          r_x_neg, n_x_neg;
    logic                          r_y_neg, n_y_neg;
    logic                          r_color, n_color;

    logic                          line_end;
    logic                          blank, digit, sign, neg, word_color;
    logic [clp_pkg::CoordW-1:0]    x_val, y_val;

    assign blank      = clp_pkg::is_blank(i_rx_byte);
    assign digit      = clp_pkg::is_digit(i_rx_byte);
    assign sign       = clp_pkg::is_sign(i_rx_byte);
    assign neg        = (i_rx_byte == clp_pkg::ChMinus);
    assign word_color = !((i_rx_byte == clp_pkg::ChLowerB) ||
                          (i_rx_byte == clp_pkg::ChUpperB));
    assign line_end   = (i_rx_byte == clp_pkg::ChLf) || (i_rx_byte == clp_pkg::ChCr) ||
                        (r_len >= LineMax);

    assign x_val = r_x_neg ? (~r_x_acc + 1'b1) : r_x_acc;
    assign y_val = r_y_neg ? (~r_y_acc + 1'b1) : r_y_acc;

    always_comb begin
        o_end.valid = i_step && (i_func == clp_pkg::FuncByte) && line_end &&
                      (r_len != '0) &&
                      (r_state == S_Y_DIG || r_state == S_AFTER_Y || r_state == S_WORD);
        o_end.piece = (r_state == S_WORD);
        o_end.x     = x_val;
        o_end.y     = y_val;
        o_end.color = (r_state == S_WORD) ? r_color : 1'b0;
    end

    always_comb begin
        n_state    = r_state;
        n_text_end = r_text_end;
        n_len      = r_len;
        n_x_acc    = r_x_acc;
        n_y_acc    = r_y_acc;
        n_x_neg    = r_x_neg;
        n_y_neg    = r_y_neg;
        n_color    = r_color;
        if (i_step && i_func == clp_pkg::FuncByte) begin
            if (line_end) begin
                n_state    = S_X_PRE;
                n_text_end = 1'b0;
                n_len      = '0;
                n_x_neg    = 1'b0;
                n_y_neg    = 1'b0;
            end else begin
                n_len = r_len + 1'b1;
                if (i_rx_byte == clp_pkg::ChNul) begin
                    n_text_end = 1'b1;
                end else if (!r_text_end) begin
                    unique case (r_state)
                        S_X_PRE: begin
                            if (blank) begin
                                n_state = S_X_PRE;
                            end else if (sign) begin
                                n_state = S_X_SIGN;
                                n_x_neg = neg;
                            end else if (digit) begin
                                n_state = S_X_DIG;
                                n_x_acc = clp_pkg::mac10('0, i_rx_byte);
                            end else begin
                                n_state = S_FAIL;
                            end
                        end
                        S_X_SIGN: begin
                            if (digit) begin
                                n_state = S_X_DIG;
                                n_x_acc = clp_pkg::mac10('0, i_rx_byte);
                            end else begin
                                n_state = S_FAIL;
                            end
                        end
                        S_X_DIG, S_Y_PRE: begin
                            if (digit && r_state == S_X_DIG) begin
                                n_x_acc = clp_pkg::mac10(r_x_acc, i_rx_byte);
                            end else if (blank) begin
                                n_state = S_Y_PRE;
                            end else if (sign) begin
                                n_state = S_Y_SIGN;
                                n_y_neg = neg;
                            end else if (digit) begin
                                n_state = S_Y_DIG;
                                n_y_acc = clp_pkg::mac10('0, i_rx_byte);
                            end else begin
                                n_state = S_FAIL;
                            end
                        end
                        S_Y_SIGN: begin
                            if (digit) begin
                                n_state = S_Y_DIG;
                                n_y_acc = clp_pkg::mac10('0, i_rx_byte);
                            end else begin
                                n_state = S_FAIL;
                            end
                        end
                        S_Y_DIG, S_AFTER_Y: begin
                            if (digit && r_state == S_Y_DIG) begin
                                n_y_acc = clp_pkg::mac10(r_y_acc, i_rx_byte);
                            end else if (blank) begin
                                n_state = S_AFTER_Y;
                            end else begin
                                n_state = S_WORD;
                                n_color = word_color;
                            end
                        end
                        S_WORD:  n_state = S_WORD;
                        S_FAIL:  n_state = S_FAIL;
                        default: n_state = S_FAIL;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_X_PRE;
            r_text_end <= 1'b0;
            r_len      <= '0;
            r_x_neg    <= 1'b0;
            r_y_neg    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_text_end <= n_text_end;
            r_len      <= n_len;
            r_x_neg    <= n_x_neg;
            r_y_neg    <= n_y_neg;
        end
        r_x_acc <= n_x_acc;
        r_y_acc <= n_y_acc;
        r_color <= n_color;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LineMax)
        else $error("line length beyond limit");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end.valid |=> (r_len == '0) && (r_state == S_X_PRE))
        else $error("line state not cleared after line end");

endmodule

// ===== sv/clp_record_gate.sv =====
module clp_record_gate #(
    parameter int unsigned MAX_PIECES  = 16,
    parameter int unsigned MAX_CORNERS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_func,
    input  clp_pkg::t_line_end             i_end,
    input  logic                           i_out_stall,
    output logic                           o_take,
    output logic                           o_out_valid,
    output logic                           o_record_kind,
    output logic [clp_pkg::SlotW-1:0]      o_slot,
    output logic signed [clp_pkg::CoordW-1:0] o_coord_x,
    output logic signed [clp_pkg::CoordW-1:0] o_coord_y,
    output logic                           o_piece_color
);

    localparam logic [clp_pkg::PieceW-1:0] MaxPieces  = clp_pkg::PieceW'(MAX_PIECES);
    localparam logic [clp_pkg::PieceW-1:0] MaxCorners = clp_pkg::PieceW'(MAX_CORNERS);

    logic [clp_pkg::PieceW-1:0]  r_pieces, n_pieces;
    logic [clp_pkg::CornerW-1:0] r_corners, n_corners;
    logic                        r_out_valid;
    logic                        r_kind;
    logic [clp_pkg::SlotW-1:0]   r_slot, n_slot;
    logic [clp_pkg::CoordW-1:0]  r_x, r_y;
    logic                        r_color;
    logic                        piece_room, corner_room, emit;

    assign o_take = !r_out_valid || !i_out_stall;

    assign piece_room  = r_pieces < MaxPieces;
    assign corner_room = {{(clp_pkg::PieceW-clp_pkg::CornerW){1'b0}}, r_corners} < MaxCorners;
    assign emit        = i_end.valid && (i_end.piece ? piece_room : corner_room);

    always_comb begin
        n_pieces  = r_pieces;
        n_corners = r_corners;
        n_slot    = i_end.piece ? r_pieces[clp_pkg::SlotW-1:0]
                                : clp_pkg::SlotW'(r_corners);
        if (i_step && i_func == clp_pkg::FuncClear) begin
            n_pieces  = '0;
            n_corners = '0;
        end else if (emit) begin
            if (i_end.piece) begin
                n_pieces = r_pieces + 1'b1;
            end else begin
                n_corners = r_corners + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pieces    <= '0;
            r_corners   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pieces  <= n_pieces;
            r_corners <= n_corners;
            if (o_take) begin
                r_out_valid <= emit;
            end
        end
        if (o_take && emit) begin
            r_kind  <= i_end.piece ? clp_pkg::KindPiece : clp_pkg::KindCorner;
            r_slot  <= n_slot;
            r_x     <= i_end.x;
            r_y     <= i_end.y;
            r_color <= i_end.color;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_record_kind = r_kind;
    assign o_slot        = r_slot;
    assign o_coord_x     = r_x;
    assign o_coord_y     = r_y;
    assign o_piece_color = r_color;

    a_corner_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_record_kind == clp_pkg::KindCorner) |-> !o_piece_color)
        else $error("corner record with colour set");

    a_piece_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pieces <= MaxPieces)
        else $error("piece count beyond limit");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_func == clp_pkg::FuncClear) |=> (r_pieces == '0) && (r_corners == '0))
        else $error("counts not cleared");

    a_emit_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> i_step && o_take)
        else $error("record raised without a stepped item");

endmodule

// ===== sv/coordinate_line_parser_top.sv =====
// result path: a closing byte passes the input register, then the result register, before its result item is valid
// throughput: one item per cycle while i_out_stall is low, set by the input register and result register
// each byte advances the field scanner once; no line buffer is held
// reset: synchronous, active low; clears line length, scan state, counts and valids
module coordinate_line_parser_top #(
    parameter int unsigned MAX_PIECES  = 16,
    parameter int unsigned MAX_CORNERS = 4,
    parameter int unsigned LINE_CHARS  = 47
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [7:0]                         i_rx_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_record_kind,
    output logic [clp_pkg::SlotW-1:0]          o_slot,
    output logic signed [clp_pkg::CoordW-1:0]  o_coord_x,
    output logic signed [clp_pkg::CoordW-1:0]  o_coord_y,
    output logic                               o_piece_color
);

    logic               r_in_valid;
    logic               r_func;
    logic [7:0]         r_byte;
    logic               take;
    logic               step;
    clp_pkg::t_line_end line_end;

    assign step       = r_in_valid && take;
    assign o_in_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_func <= i_func;
            r_byte <= i_rx_byte;
        end
    end

    clp_field_scan #(
        .LINE_CHARS (LINE_CHARS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_func    (r_func),
        .i_rx_byte (r_byte),
        .o_end     (line_end)
    );

    clp_record_gate #(
        .MAX_PIECES  (MAX_PIECES),
        .MAX_CORNERS (MAX_CORNERS)
    ) u_gate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_func        (r_func),
        .i_end         (line_end),
        .i_out_stall   (i_out_stall),
        .o_take        (take),
        .o_out_valid   (o_out_valid),
        .o_record_kind (o_record_kind),
        .o_slot        (o_slot),
        .o_coord_x     (o_coord_x),
        .o_coord_y     (o_coord_y),
        .o_piece_color (o_piece_color)
    );

endmodule
